>>> hw/rtl/ftrm_pkg.sv
// ----------------------------------------------------------------------------
// ftrm_pkg
// Shared types, constants and helpers of the fan tach rpm meter.
// ----------------------------------------------------------------------------
package ftrm_pkg;

  localparam int NOW_W      = 32;
  localparam int CNT_W      = 16;
  localparam int RPM_W      = 16;
  localparam int PPR_W      = 16;
  localparam int INTV_W     = 16;
  localparam int DUTY_W     = 17;
  localparam int PWM_W      = 8;
  localparam int NUM_W      = 32;              // pulses * 60000
  localparam int DEN_W      = NOW_W + PPR_W;   // elapsed * pulses_per_rev
  localparam int DIV_W      = 50;              // holds 2*num + den and 2*den
  localparam int DIV_CNT_W  = 6;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [NUM_W-1:0]  MINUTE_MS      = 32'd60000;
  localparam logic [RPM_W-1:0]  RPM_MAX        = 16'hFFFF;
  localparam logic [DUTY_W-1:0] DUTY_FULL      = 17'h10000;
  localparam logic [PPR_W-1:0]  PPR_RESET      = 16'd2;
  localparam logic [INTV_W-1:0] INTERVAL_RESET = 16'd1000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PPR      = 2'd0,
    CFG_INTERVAL = 2'd1,
    CFG_DUTY     = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [PPR_W-1:0]  pulses_per_rev;
    logic [INTV_W-1:0] sample_interval_ms;
    logic [DUTY_W-1:0] duty_fraction;
  } cfg_t;

  typedef struct packed {
    logic             window;   // this time update closes a window
    logic [CNT_W-1:0] pulses;
    logic [NOW_W-1:0] elapsed;
  } job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } back_state_t;

  function automatic logic [PWM_W-1:0] pwm_from_duty(input logic [DUTY_W-1:0] duty);
    logic [DUTY_W-1:0] d;
    logic [24:0]       p;
    d = (duty > DUTY_FULL) ? DUTY_FULL : duty;
    p = 25'(d) * 25'd255 + 25'd32768;
    return p[23:16];
  endfunction

endpackage

>>> hw/rtl/ftrm_front.sv
// ----------------------------------------------------------------------------
// ftrm_front
// Accepts tach and time items, keeps the pulse count and window start,
// and queues one job per item for the back end.
// ----------------------------------------------------------------------------
module ftrm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic                              s_tuser,   // [0] operation
  input  logic [ftrm_pkg::NOW_W-1:0]        s_tdata,   // [31:0] now_ms
  input  ftrm_pkg::cfg_t                    cfg,
  input  ftrm_pkg::q_stat_t                 q_stat,
  output logic                              push,
  output ftrm_pkg::job_t                    push_job
);
  import ftrm_pkg::*;

  logic [CNT_W-1:0] pulse_counter;
  logic [NOW_W-1:0] last_sample_time;
  logic [NOW_W-1:0] elapsed;
  logic             window;

  assign elapsed  = s_tdata - last_sample_time;   // mod 2^32
  assign window   = s_tuser && (elapsed >= NOW_W'(cfg.sample_interval_ms));
  assign s_tready = !q_stat.full;
  assign push     = s_tvalid && s_tready;

  assign push_job.window  = window;
  assign push_job.pulses  = pulse_counter;
  assign push_job.elapsed = elapsed;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_counter    <= '0;
      last_sample_time <= '0;
    end else if (push) begin
      if (window) begin
        pulse_counter    <= '0;
        last_sample_time <= s_tdata;
      end else if (!s_tuser) begin
        pulse_counter <= pulse_counter + 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/ftrm_queue.sv
// ----------------------------------------------------------------------------
// ftrm_queue
// Short job FIFO between front and back end.
// ----------------------------------------------------------------------------
module ftrm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ftrm_pkg::job_t    push_job,
  input  logic              pop,
  output ftrm_pkg::job_t    pop_job,
  output ftrm_pkg::q_stat_t q_stat
);
  import ftrm_pkg::*;

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign pop_job      = mem[rd_ptr];
  assign q_stat.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign q_stat.valid = (count != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // depth is a power of two, so pointers wrap naturally
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hw/rtl/ftrm_back.sv
// ----------------------------------------------------------------------------
// ftrm_back
// Runs queued jobs: rpm by multiply then restoring division, and drives
// the result register.
// ----------------------------------------------------------------------------
module ftrm_back (
  input  logic                            clk,
  input  logic                            rst,
  input  ftrm_pkg::cfg_t                  cfg,
  input  ftrm_pkg::q_stat_t               q_stat,
  input  ftrm_pkg::job_t                  pop_job,
  output logic                            pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [15:0] rpm, [16] sample_taken, [24:17] pwm_level, [31:25] zero
  output logic [ftrm_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ftrm_pkg::*;

  back_state_t          state, state_next;
  job_t                 cur;
  logic [RPM_W-1:0]     rpm_value;
  logic                 taken;
  logic [NUM_W-1:0]     prod_num;
  logic [DEN_W-1:0]     prod_den;
  logic [DIV_W-1:0]     n_reg;
  logic [DIV_W-1:0]     d_reg;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_CNT_W-1:0] cnt;

  logic                 out_free;
  logic                 load_out;
  logic                 zero_case;
  logic                 div_last;
  logic [DIV_W:0]       r_shift;
  logic [DIV_W:0]       r_sub;
  logic                 ge;
  logic [DIV_W-1:0]     quo_next;

  assign out_free  = !m_tvalid || m_tready;
  assign zero_case = (pop_job.elapsed == '0) || (cfg.pulses_per_rev == '0);
  assign div_last  = (cnt == DIV_CNT_W'(DIV_W - 1));
  assign r_shift   = {rem, n_reg[DIV_W-1]};
  assign r_sub     = r_shift - {1'b0, d_reg};
  assign ge        = !r_sub[DIV_W];
  assign quo_next  = {quo[DIV_W-2:0], ge};

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE: begin
        if (q_stat.valid) begin
          if (!pop_job.window || zero_case) state_next = BK_DONE;
          else                              state_next = BK_MUL;
        end
      end
      BK_MUL:  state_next = BK_PREP;
      BK_PREP: state_next = BK_DIV;
      BK_DIV: begin
        if (div_last) state_next = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    case (state)
      BK_IDLE: pop      = q_stat.valid;
      BK_DONE: load_out = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_value <= '0;
    end else if (state == BK_IDLE && pop && pop_job.window && zero_case) begin
      rpm_value <= '0;
    end else if (state == BK_DIV && div_last) begin
      rpm_value <= (|quo_next[DIV_W-1:RPM_W]) ? RPM_MAX : quo_next[RPM_W-1:0];
    end
  end

  // q = (2*num + den) / (2*den), one quotient bit per cycle
  always_ff @(posedge clk) begin
    case (state)
      BK_IDLE: begin
        if (pop) begin
          cur   <= pop_job;
          taken <= pop_job.window;
        end
      end
      BK_MUL: begin
        prod_num <= NUM_W'(cur.pulses) * MINUTE_MS;
        prod_den <= DEN_W'(cur.elapsed) * DEN_W'(cfg.pulses_per_rev);
      end
      BK_PREP: begin
        n_reg <= DIV_W'({prod_num, 1'b0}) + DIV_W'(prod_den);
        d_reg <= DIV_W'({prod_den, 1'b0});
        rem   <= '0;
        quo   <= '0;
        cnt   <= '0;
      end
      BK_DIV: begin
        rem   <= ge ? r_sub[DIV_W-1:0] : r_shift[DIV_W-1:0];
        n_reg <= {n_reg[DIV_W-2:0], 1'b0};
        quo   <= quo_next;
        cnt   <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {7'b0, pwm_from_duty(cfg.duty_fraction), taken, rpm_value};
    end
  end

endmodule

>>> hw/rtl/fan_tach_rpm_meter.sv
// ----------------------------------------------------------------------------
// fan_tach_rpm_meter
// Fan tach pulse counter with windowed rpm measurement and PWM level.
// ----------------------------------------------------------------------------
// Flow: a job passes BK_IDLE then BK_DONE; a closing update with nonzero
//   elapsed and pulses_per_rev also passes BK_MUL, BK_PREP and the 50-step
//   restoring divider. The back end runs one job at a time and holds in
//   BK_DONE on a stall; the front end takes items while the queue has room.
// Reset: synchronous; clears counter, sample time, rpm and queue, loads
//   register defaults (pulses_per_rev 2, interval 1000, duty 0).
module fan_tach_rpm_meter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic                            s_tuser,    // [0] operation
  input  logic [ftrm_pkg::NOW_W-1:0]      s_tdata,    // [31:0] now_ms
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [15:0] rpm, [16] sample_taken, [24:17] pwm_level, [31:25] zero
  output logic [ftrm_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [ftrm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ftrm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ftrm_pkg::*;

  cfg_t    cfg;
  q_stat_t q_stat;
  job_t    push_job;
  job_t    pop_job;
  logic    push;
  logic    pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulses_per_rev     <= PPR_RESET;
      cfg.sample_interval_ms <= INTERVAL_RESET;
      cfg.duty_fraction      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PPR:      cfg.pulses_per_rev     <= cfg_wdata[PPR_W-1:0];
        CFG_INTERVAL: cfg.sample_interval_ms <= cfg_wdata[INTV_W-1:0];
        CFG_DUTY:     cfg.duty_fraction      <= cfg_wdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  ftrm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  ftrm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  ftrm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_stat   (q_stat),
    .pop_job  (pop_job),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_stat.valid)
    else $error("job queue underflow");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[OUT_DATA_W-1:25] == '0))
    else $error("result padding not zero");

endmodule
